// ===== sv/pdc_pkg.sv =====
// shared constants and control types for the pwm duty-cycle capture block
`default_nettype none

package pdc_pkg;

  // default configuration of the capture timer and the duty fraction
  localparam int TIMER_BITS_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed port widths
  localparam int TS_W   = 32;
  localparam int TICK_W = 32;
  localparam int DUTY_W = 17;

  // sequencer step flags, one set per cycle
  typedef struct packed {
    logic idle;
    logic st_high;
    logic st_per;
    logic st_cmp;
    logic st_div;
    logic st_done;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== sv/pdc_alu.sv =====
// shared subtractor with borrow, used for time differences, compare and divide steps
`default_nettype none

module pdc_alu #(
  parameter int W = pdc_pkg::TIMER_BITS_DEF + 1
) (
  input  wire logic [W-1:0] op_a,
  input  wire logic [W-1:0] op_b,
  output logic      [W-1:0] diff,
  output logic              borrow
);

  logic [W:0] full;

  // one wide subtract, borrow marks a below b
  always_comb begin
    full   = {1'b0, op_a} - {1'b0, op_b};
    diff   = full[W-1:0];
    borrow = full[W];
  end

endmodule

`default_nettype wire

// ===== sv/pdc_seq.sv =====
// step sequencer driving the shared subtractor through one measurement
`default_nettype none

module pdc_seq #(
  parameter int FRACTION_BITS = pdc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          saturate,
  input  wire logic          out_free,
  output pdc_pkg::ctrl_t     ctrl
);

  localparam int CW = $clog2(FRACTION_BITS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_HIGH = 6'b000010,
    ST_PER  = 6'b000100,
    ST_CMP  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          div_last;

  assign div_last = (cnt_r == CW'(FRACTION_BITS - 1));

  // next step
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_HIGH;
      end
      ST_HIGH: state_nxt = ST_PER;
      ST_PER:  state_nxt = ST_CMP;
      ST_CMP: begin
        cnt_nxt = '0;
        if (saturate) state_nxt = ST_DONE;
        else          state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + CW'(1);
        if (div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // decoded step flags
  always_comb begin
    ctrl.idle    = (state_r == ST_IDLE);
    ctrl.st_high = (state_r == ST_HIGH);
    ctrl.st_per  = (state_r == ST_PER);
    ctrl.st_cmp  = (state_r == ST_CMP);
    ctrl.st_div  = (state_r == ST_DIV);
    ctrl.st_done = (state_r == ST_DONE);
  end

  // divide runs exactly FRACTION_BITS steps before finishing
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && !div_last |=> (state_r == ST_DIV))
    else $error("divide left early");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && div_last |=> (state_r == ST_DONE))
    else $error("divide overran");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && start |=> (state_r == ST_HIGH))
    else $error("request not taken up");

endmodule

`default_nettype wire

// ===== sv/pwm_duty_cycle_capture_core.sv =====
// top level of the pwm duty-cycle capture block: edge state, datapath and result register
//
// Usage
//   Input channel (in_valid / in_stall): one request per pin edge, carrying the
//   pin level after the edge and the free-running timer value at that edge.
//   The first rising edge arms the block; falling edges once armed record the fall time;
//   each later rising edge yields one result on the output channel
//   (out_valid / out_stall): period, high time and duty ratio (unsigned Q1.16
//   by default, saturated at 1.0, also 1.0 for a zero period).
//   A falling edge or the arming rise is absorbed without making the block
//   busy. A measuring rise steps through high time, period, compare and
//   hand-off, with a restoring division of FRACTION_BITS quotient bits
//   before hand-off when the ratio is below one. Every step goes through
//   the one shared subtractor; in_stall is high while it is busy.
//   Reset clears the armed flag and both stored edge times to zero.
//   A stalled result is held in the output register; the next request is
//   accepted meanwhile and its result waits in the hand-off step until the
//   output register frees.
`default_nettype none

module pwm_duty_cycle_capture_core #(
  parameter int TIMER_BITS    = pdc_pkg::TIMER_BITS_DEF,
  parameter int FRACTION_BITS = pdc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_pin_level,
  input  wire logic [pdc_pkg::TS_W-1:0]    in_timestamp,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [pdc_pkg::TICK_W-1:0]       out_period_ticks,
  output logic [pdc_pkg::TICK_W-1:0]       out_high_ticks,
  output logic [pdc_pkg::DUTY_W-1:0]       out_duty_ratio
);

  localparam int TB = TIMER_BITS;
  localparam int AW = TIMER_BITS + 1;
  localparam int QW = FRACTION_BITS + 1;
  localparam logic [QW-1:0] Q_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  pdc_pkg::ctrl_t ctrl;

  logic          armed_r;
  logic [TB-1:0] rise_r;
  logic [TB-1:0] fall_r;
  logic [TB-1:0] ts_r;
  logic [TB-1:0] period_r;
  logic [TB-1:0] high_r;
  logic [TB-1:0] rem_r;
  logic [QW-1:0] q_r;

  logic          out_valid_r;
  logic [pdc_pkg::TICK_W-1:0] out_period_r;
  logic [pdc_pkg::TICK_W-1:0] out_high_r;
  logic [pdc_pkg::DUTY_W-1:0] out_duty_r;

  logic          in_acc;
  logic          start;
  logic          out_free;
  logic          load;
  logic [63:0]   ts_ext;
  logic [TB-1:0] ts_in;
  logic [AW-1:0] rem_sh;
  logic [AW-1:0] op_a, op_b, diff;
  logic          borrow;
  logic [63:0]   period_ext, high_ext;
  logic [47:0]   q_ext;

  // input handshake and timer value reduced to the timer width
  assign in_stall = !ctrl.idle;
  assign in_acc   = in_valid && !in_stall;
  assign start    = in_acc && in_pin_level && armed_r;
  assign ts_ext   = 64'(in_timestamp);
  assign ts_in    = ts_ext[TB-1:0];
  assign rem_sh   = {rem_r, 1'b0};

  // result register hand-off
  assign out_free = !out_valid_r || !out_stall;
  assign load     = ctrl.st_done && out_free;

  // operand selection for the shared subtractor
  always_comb begin
    unique if (ctrl.st_high) begin
      op_a = {1'b0, fall_r};
      op_b = {1'b0, rise_r};
    end else if (ctrl.st_per) begin
      op_a = {1'b0, ts_r};
      op_b = {1'b0, rise_r};
    end else if (ctrl.st_cmp) begin
      op_a = {1'b0, high_r};
      op_b = {1'b0, period_r};
    end else if (ctrl.st_div) begin
      op_a = rem_sh;
      op_b = {1'b0, period_r};
    end else begin
      op_a = '0;
      op_b = '0;
    end
  end

  pdc_alu #(.W(AW)) u_alu (
    .op_a   (op_a),
    .op_b   (op_b),
    .diff   (diff),
    .borrow (borrow)
  );

  pdc_seq #(.FRACTION_BITS(FRACTION_BITS)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .saturate (!borrow),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // edge state: arming flag and stored rise and fall times
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      rise_r  <= '0;
      fall_r  <= '0;
    end else begin
      if (in_acc && !in_pin_level && armed_r) fall_r <= ts_in;
      if (in_acc && in_pin_level && !armed_r) begin
        rise_r  <= ts_in;
        armed_r <= 1'b1;
      end
      if (ctrl.st_per) rise_r <= ts_r;
    end
  end

  // measurement datapath, payload only
  always_ff @(posedge clk) begin
    if (start) ts_r <= ts_in;
    if (ctrl.st_high) high_r <= diff[TB-1:0];
    if (ctrl.st_per) period_r <= diff[TB-1:0];
    if (ctrl.st_cmp) begin
      rem_r <= high_r;
      q_r   <= borrow ? '0 : Q_ONE;
    end
    // restoring divide step, one quotient bit per cycle
    if (ctrl.st_div) begin
      if (!borrow) begin
        rem_r <= diff[TB-1:0];
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[TB-1:0];
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
    end
  end

  // widths of the results reduced to the port widths
  assign period_ext = 64'(period_r);
  assign high_ext   = 64'(high_r);
  assign q_ext      = 48'(q_r);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_period_r <= period_ext[pdc_pkg::TICK_W-1:0];
      out_high_r   <= high_ext[pdc_pkg::TICK_W-1:0];
      out_duty_r   <= q_ext[pdc_pkg::DUTY_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_period_ticks = out_period_r;
  assign out_high_ticks   = out_high_r;
  assign out_duty_ratio   = out_duty_r;

  // a measuring rise keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> in_stall)
    else $error("request taken while measuring");

  // the ratio never exceeds one when handed off
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (q_r <= Q_ONE))
    else $error("duty ratio above one");

  // a result is only ever loaded while the block is armed
  a_armed: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> armed_r)
    else $error("result without reference rise");

  // an unstalled result leaves unless a new one replaces it
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !load |=> !out_valid_r)
    else $error("result delivered twice");

endmodule

`default_nettype wire

// ===== bench/tb_pwm_duty_cycle_capture_core.sv =====
// testbench for the pwm duty-cycle capture core: edge stimulus, duty prediction and checking
`timescale 1ns / 1ps

module tb_pwm_duty_cycle_capture_core;

  localparam int FRAC = pdc_pkg::FRACTION_BITS_DEF;
  localparam bit LEVEL_FALL = 1'b0;
  localparam bit LEVEL_RISE = 1'b1;
  localparam int RANDOM_ITEMS = 500;
  localparam bit [pdc_pkg::DUTY_W-1:0] DUTY_ONE = {1'b1, {FRAC{1'b0}}};

  typedef struct {
    bit [pdc_pkg::TICK_W-1:0] period;
    bit [pdc_pkg::TICK_W-1:0] high;
    bit [pdc_pkg::DUTY_W-1:0] duty;
  } duty_meas_t;

  // tracks the edge state and holds the measurements still owed by the core
  class duty_scoreboard;
    bit armed;
    bit [pdc_pkg::TS_W-1:0] rise_ts;
    bit [pdc_pkg::TS_W-1:0] fall_ts;
    duty_meas_t owed_q[$];
    int mismatches;

    function new();
      armed = 1'b0;
      rise_ts = '0;
      fall_ts = '0;
      mismatches = 0;
    endfunction

    // high/period as unsigned fixed point, saturated at one
    function bit [pdc_pkg::DUTY_W-1:0] duty_q(bit [pdc_pkg::TICK_W-1:0] num,
                                              bit [pdc_pkg::TICK_W-1:0] den);
      bit [pdc_pkg::TICK_W:0] rem;
      bit [pdc_pkg::DUTY_W-1:0] q;
      if (den == 0 || num >= den) return DUTY_ONE;
      rem = {1'b0, num};
      q = '0;
      for (int i = 0; i < FRAC; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= {1'b0, den}) begin
          rem = rem - {1'b0, den};
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    // an accepted edge request: update state, owe a measurement on an armed rise
    function void note_edge(bit level, bit [pdc_pkg::TS_W-1:0] ts);
      duty_meas_t m;
      if (level == LEVEL_FALL) begin
        if (armed) fall_ts = ts;
        return;
      end
      if (!armed) begin
        armed = 1'b1;
        rise_ts = ts;
        return;
      end
      m.period = ts - rise_ts;
      m.high = fall_ts - rise_ts;
      m.duty = duty_q(m.high, m.period);
      owed_q.push_back(m);
      rise_ts = ts;
    endfunction

    // an accepted measurement: compare with the oldest one owed
    function void check_result(bit [pdc_pkg::TICK_W-1:0] period,
                               bit [pdc_pkg::TICK_W-1:0] high,
                               bit [pdc_pkg::DUTY_W-1:0] duty);
      duty_meas_t m;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: period %h high %h duty %h", period, high, duty);
        return;
      end
      m = owed_q.pop_front();
      if (period !== m.period || high !== m.high || duty !== m.duty) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected period %h high %h duty %h, got %h %h %h",
                   m.period, m.high, m.duty, period, high, duty);
      end
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction

    function bit failed();
      return (mismatches != 0) || (owed_q.size() != 0);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_pin_level;
  logic [pdc_pkg::TS_W-1:0] in_timestamp;
  logic out_valid;
  logic out_stall;
  logic [pdc_pkg::TICK_W-1:0] out_period_ticks;
  logic [pdc_pkg::TICK_W-1:0] out_high_ticks;
  logic [pdc_pkg::DUTY_W-1:0] out_duty_ratio;

  duty_scoreboard sb;
  bit send_burst;
  int send_count;
  bit [pdc_pkg::TS_W-1:0] last_rise;

  pwm_duty_cycle_capture_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pin_level(in_pin_level),
    .in_timestamp(in_timestamp),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_period_ticks(out_period_ticks),
    .out_high_ticks(out_high_ticks),
    .out_duty_ratio(out_duty_ratio)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one edge request, after a random gap; burst stretches have no gap
  task automatic send_edge(bit level, bit [pdc_pkg::TS_W-1:0] ts);
    int gap;
    if (send_count % 40 == 0) send_burst = ($urandom_range(2) == 0);
    send_count++;
    gap = send_burst ? 0 : $urandom_range(15);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_pin_level <= level;
    in_timestamp <= ts;
    do @(posedge clk); while (in_stall);
    sb.note_edge(level, ts);
    if (level == LEVEL_RISE) last_rise = ts;
  endtask

  // hold off the sender until every owed measurement has come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // one pwm cycle from the last rise, a fall then a rise, with random period and high time
  task automatic send_cycle();
    int k;
    bit [pdc_pkg::TS_W-1:0] mask;
    bit [pdc_pkg::TS_W-1:0] period;
    bit [pdc_pkg::TS_W-1:0] high;
    k = $urandom_range(32, 1);
    mask = (k == 32) ? '1 : ((32'd1 << k) - 1);
    period = $urandom & mask;
    if ($urandom_range(9) == 0) high = $urandom & mask;
    else high = $urandom_range(period);
    send_edge(LEVEL_FALL, last_rise + high);
    send_edge(LEVEL_RISE, last_rise + period);
  endtask

  // result side: random stall before each result, with stretches of none
  initial begin
    int n;
    int taken;
    bit eager;
    taken = 0;
    eager = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 32 == 0) eager = ($urandom_range(2) == 0);
      n = eager ? 0 : $urandom_range(15);
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_period_ticks, out_high_ticks, out_duty_ratio);
      taken++;
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // reset, directed edges, random edges, drain and verdict
  initial begin
    int sent;
    int r;
    bit pressed;
    bit [pdc_pkg::TS_W-1:0] ts;
    sb = new();
    send_burst = 1'b0;
    send_count = 0;
    last_rise = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pin_level = 1'b0;
    in_timestamp = '0;
    out_stall = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // fall before arming is ignored, then arm and a zero period
    send_edge(LEVEL_FALL, 32'hFFFF_FFFF);
    send_edge(LEVEL_RISE, 32'h0000_0000);
    send_edge(LEVEL_RISE, 32'h0000_0000);
    // no fall since reset: stale fall time gives zero duty
    send_edge(LEVEL_RISE, 32'd100);
    send_edge(LEVEL_FALL, 32'd130);
    send_edge(LEVEL_RISE, 32'd200);
    // fall overwritten by a second fall
    send_edge(LEVEL_FALL, 32'd250);
    send_edge(LEVEL_FALL, 32'd260);
    send_edge(LEVEL_RISE, 32'd300);
    // stale fall before the reference: high above period saturates
    send_edge(LEVEL_RISE, 32'hFFFF_FF00);
    // timer wraps between rise and fall
    send_edge(LEVEL_FALL, 32'h0000_0010);
    send_edge(LEVEL_RISE, 32'h0000_0100);
    // high equal to period
    send_edge(LEVEL_FALL, 32'h0000_0180);
    send_edge(LEVEL_RISE, 32'h0000_0180);
    // largest period and high
    send_edge(LEVEL_FALL, 32'h0000_017F);
    send_edge(LEVEL_RISE, 32'h0000_017F);
    // ratio just below one
    send_edge(LEVEL_FALL, 32'h0000_017D);
    send_edge(LEVEL_RISE, 32'h0000_017E);
    // ratio rounds down to zero over a long period
    send_edge(LEVEL_FALL, 32'h0000_017F);
    send_edge(LEVEL_RISE, 32'h8000_017E);
    // timer wraps between fall and rise
    send_edge(LEVEL_FALL, 32'hFFFF_FFFF);
    send_edge(LEVEL_RISE, 32'h0000_0000);
    drain();

    // random part: mostly clean cycles, some extra falls, double rises and noise
    sent = 0;
    pressed = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 80) begin
        send_cycle();
        sent += 2;
      end else if (r < 88) begin
        send_edge(LEVEL_FALL, $urandom);
        sent++;
      end else if (r < 94) begin
        ts = last_rise + ($urandom & 32'h0000_FFFF);
        send_edge(LEVEL_RISE, ts);
        sent++;
      end else begin
        send_edge(1'($urandom_range(1)), $urandom);
        sent++;
      end
      if (!pressed && sent >= RANDOM_ITEMS / 2) begin
        pressed = 1'b1;
        drain();
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (!sb.failed()) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
